// File: hdl/ptd_pkg.sv
`default_nettype none

package ptd_pkg;

	// table geometry
	localparam int SLOTS  = 16;
	localparam int LEVELS = 4;

	// fixed field widths
	localparam int CFG_W    = 5;
	localparam int REQ_W    = 3;
	localparam int HANDLE_W = 16;
	localparam int PRI_W    = 2;
	localparam int RS_W     = 2;
	localparam int STATUS_W = 3;
	localparam int RUN_W    = 7;

	// derived widths
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IDX_W  = $clog2(SLOTS + 1);
	localparam int CNT_W  = (IDX_W > CFG_W) ? IDX_W : CFG_W;
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int LCMP_W = (LVL_W > PRI_W) ? LVL_W : PRI_W;

	localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = CFG_W'(16);
	localparam logic [RUN_W-1:0] RUN_MAX          = RUN_W'(64);

	// request codes
	localparam logic [REQ_W-1:0] REQ_CREATE   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DESTROY  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DISPATCH = 3'd2;
	localparam logic [REQ_W-1:0] REQ_COMPLETE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_QUERY    = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] STS_BAD_HANDLE = 3'd1;
	localparam logic [STATUS_W-1:0] STS_NOT_FOUND  = 3'd2;
	localparam logic [STATUS_W-1:0] STS_FULL       = 3'd3;
	localparam logic [STATUS_W-1:0] STS_WRONG      = 3'd4;
	localparam logic [STATUS_W-1:0] STS_DONE       = 3'd5;

	// run states
	localparam logic [RS_W-1:0] RS_READY      = 2'd0;
	localparam logic [RS_W-1:0] RS_RUNNING    = 2'd1;
	localparam logic [RS_W-1:0] RS_YIELDED    = 2'd2;
	localparam logic [RS_W-1:0] RS_TERMINATED = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [HANDLE_W-1:0] task_handle;
		logic [PRI_W-1:0]    task_priority;
		logic                outcome;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] result_handle;
		logic [PRI_W-1:0]    result_priority;
		logic [RS_W-1:0]     result_state;
		logic [RUN_W-1:0]    tasks_run;
	} rsp_t;

endpackage

`default_nettype wire

// File: hdl/priority_task_table_dispatcher.sv
`default_nettype none
// flow: requests refused at once go from idle straight to the response state; the others first
//   visit k slots in the scan state with the single-slot compare unit (create and lookups: up to
//   n + 1, dispatch: up to LEVELS * (n + 1), complete: 1); n = usable slot count
// handshake: one request at a time, the next beat is taken once the result of the last
//   one is loaded into the output register; the response state waits while out_stall holds it
// reset: asynchronous, clears the slot table, live and pass counts, handle counter back to 1, slots_in_use back to 16
module priority_task_table_dispatcher (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire ptd_pkg::req_t               in_data,
	output logic                             out_valid,
	input  wire                              out_stall,
	output ptd_pkg::rsp_t                    out_data,
	input  wire                              cfg_we,
	input  wire [ptd_pkg::CFG_W-1:0]         cfg_wdata
);
	import ptd_pkg::*;

	// small sequencer: take a beat, walk the table one slot a cycle, hand over the result
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	state_t state_q;

	// slot table, 16 entries in flops, read through one shared index
	logic [HANDLE_W-1:0] handle_q [SLOTS];
	logic [PRI_W-1:0]    pri_q    [SLOTS];
	logic [RS_W-1:0]     rs_q     [SLOTS];

	logic [CFG_W-1:0]    slots_in_use_q;
	logic [IDX_W-1:0]    live_q;
	logic [HANDLE_W-1:0] handle_ctr_q;
	logic [SLOT_W-1:0]   running_slot_q;
	logic                running_valid_q;
	logic [LVL_W-1:0]    scan_level_q;
	logic [IDX_W-1:0]    scan_slot_q;
	logic [RUN_W-1:0]    pass_count_q;

	// request in flight
	req_t                req_q;
	logic [IDX_W-1:0]    idx_q;
	rsp_t                res_q;
	rsp_t                out_q;
	logic                out_valid_q;

	// combinational view of the slot under the index
	logic [IDX_W-1:0]    usable;
	logic                in_range;
	logic [SLOT_W-1:0]   rd_slot;
	logic [HANDLE_W-1:0] rd_handle;
	logic [PRI_W-1:0]    rd_pri;
	logic [RS_W-1:0]     rd_rs;
	logic                cand;
	logic [HANDLE_W-1:0] handle_ctr_inc;
	logic [RS_W-1:0]     done_rs;

	// capacity is clipped to the table size
	assign usable = (CNT_W'(slots_in_use_q) > CNT_W'(SLOTS)) ? IDX_W'(SLOTS)
		: IDX_W'(slots_in_use_q);
	assign in_range  = idx_q < usable;
	assign rd_slot   = idx_q[SLOT_W-1:0];
	assign rd_handle = handle_q[rd_slot];
	assign rd_pri    = pri_q[rd_slot];
	assign rd_rs     = rs_q[rd_slot];

	// dispatch candidate at the current level
	always_comb begin
		cand = (rd_handle != '0)
			&& (LCMP_W'(rd_pri) == LCMP_W'(scan_level_q))
			&& (rd_rs inside {RS_READY, RS_YIELDED});
	end

	// next handle, never zero after a wrap
	assign handle_ctr_inc = (handle_ctr_q + HANDLE_W'(1) == '0) ? HANDLE_W'(1)
		: handle_ctr_q + HANDLE_W'(1);
	assign done_rs = req_q.outcome ? RS_TERMINATED : RS_YIELDED;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			for (int i = 0; i < SLOTS; i++) begin
				handle_q[i] <= '0;
				pri_q[i]    <= '0;
				rs_q[i]     <= '0;
			end
			slots_in_use_q  <= SLOTS_IN_USE_RST;
			live_q          <= '0;
			handle_ctr_q    <= HANDLE_W'(1);
			running_slot_q  <= '0;
			running_valid_q <= 1'b0;
			scan_level_q    <= LVL_W'(LEVELS - 1);
			scan_slot_q     <= '0;
			pass_count_q    <= '0;
			out_valid_q     <= 1'b0;
			idx_q           <= '0;
			req_q           <= '0;
			res_q           <= '0;
			out_q           <= '0;
		end else begin
			if (cfg_we) begin
				slots_in_use_q <= cfg_wdata;
			end

			// result beat leaves the output register (the response state reloads it itself)
			if (out_valid_q && !out_stall && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					// res_q is already clear here, it is emptied when handed over
					if (in_valid) begin
						req_q <= in_data;
						case (in_data.req_type)
							REQ_CREATE: begin
								idx_q <= '0;
								if (live_q < usable) begin
									state_q <= S_SCAN;
								end else begin
									res_q.status <= STS_FULL;
									state_q      <= S_RESP;
								end
							end
							REQ_DESTROY, REQ_QUERY: begin
								idx_q <= '0;
								if (in_data.task_handle == '0) begin
									res_q.status <= STS_BAD_HANDLE;
									state_q      <= S_RESP;
								end else begin
									state_q <= S_SCAN;
								end
							end
							REQ_DISPATCH: begin
								if (running_valid_q) begin
									res_q.status <= STS_WRONG;
									state_q      <= S_RESP;
								end else begin
									// pass resumes where the last dispatch left it
									idx_q   <= scan_slot_q;
									state_q <= S_SCAN;
								end
							end
							REQ_COMPLETE: begin
								if (running_valid_q) begin
									idx_q   <= IDX_W'(running_slot_q);
									state_q <= S_SCAN;
								end else begin
									res_q.status <= STS_WRONG;
									state_q      <= S_RESP;
								end
							end
							default: begin
								// unknown request: no change
								res_q.status <= STS_WRONG;
								state_q      <= S_RESP;
							end
						endcase
					end
				end

				S_SCAN: begin
					case (req_q.req_type)
						REQ_CREATE: begin
							if (!in_range) begin
								res_q.status <= STS_FULL;
								state_q      <= S_RESP;
							end else if (rd_handle == '0) begin
								handle_q[rd_slot]     <= handle_ctr_q;
								pri_q[rd_slot]        <= req_q.task_priority;
								rs_q[rd_slot]         <= RS_READY;
								handle_ctr_q          <= handle_ctr_inc;
								live_q                <= live_q + IDX_W'(1);
								res_q.status          <= STS_OK;
								res_q.result_handle   <= handle_ctr_q;
								res_q.result_priority <= req_q.task_priority;
								res_q.result_state    <= RS_READY;
								state_q               <= S_RESP;
							end else begin
								idx_q <= idx_q + IDX_W'(1);
							end
						end
						REQ_DESTROY, REQ_QUERY: begin
							if (!in_range) begin
								res_q.status <= STS_NOT_FOUND;
								state_q      <= S_RESP;
							end else if (rd_handle == req_q.task_handle) begin
								state_q <= S_RESP;
								if (req_q.req_type == REQ_QUERY) begin
									res_q.status          <= STS_OK;
									res_q.result_handle   <= rd_handle;
									res_q.result_priority <= rd_pri;
									res_q.result_state    <= rd_rs;
								end else if (rd_rs == RS_RUNNING) begin
									res_q.status <= STS_WRONG;
								end else begin
									handle_q[rd_slot] <= '0;
									pri_q[rd_slot]    <= '0;
									rs_q[rd_slot]     <= '0;
									if (live_q != '0) begin
										live_q <= live_q - IDX_W'(1);
									end
									res_q.status <= STS_OK;
								end
							end else begin
								idx_q <= idx_q + IDX_W'(1);
							end
						end
						REQ_DISPATCH: begin
							if (!in_range) begin
								if (scan_level_q == '0) begin
									// pass exhausted: report and rearm
									res_q.status    <= STS_DONE;
									res_q.tasks_run <= pass_count_q;
									scan_level_q    <= LVL_W'(LEVELS - 1);
									scan_slot_q     <= '0;
									pass_count_q    <= '0;
									state_q         <= S_RESP;
								end else begin
									scan_level_q <= scan_level_q - LVL_W'(1);
									scan_slot_q  <= '0;
									idx_q        <= '0;
								end
							end else if (cand) begin
								rs_q[rd_slot]         <= RS_RUNNING;
								running_slot_q        <= rd_slot;
								running_valid_q       <= 1'b1;
								scan_slot_q           <= idx_q + IDX_W'(1);
								if (pass_count_q < RUN_MAX) begin
									pass_count_q <= pass_count_q + RUN_W'(1);
								end
								res_q.status          <= STS_OK;
								res_q.result_handle   <= rd_handle;
								res_q.result_priority <= rd_pri;
								res_q.result_state    <= RS_RUNNING;
								state_q               <= S_RESP;
							end else begin
								idx_q <= idx_q + IDX_W'(1);
							end
						end
						REQ_COMPLETE: begin
							rs_q[rd_slot]         <= done_rs;
							running_valid_q       <= 1'b0;
							res_q.status          <= STS_OK;
							res_q.result_handle   <= rd_handle;
							res_q.result_priority <= rd_pri;
							res_q.result_state    <= done_rs;
							state_q               <= S_RESP;
						end
						default: begin
							res_q.status <= STS_WRONG;
							state_q      <= S_RESP;
						end
					endcase
				end

				S_RESP: begin
					// load the output register once it is free or draining
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						res_q       <= '0;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the running slot is always marked running in the table
	a_running_marked: assert property (@(posedge clk) disable iff (!arst_n)
		running_valid_q |-> (rs_q[running_slot_q] == RS_RUNNING))
		else $error("running slot not marked running");

	// handle counter never lands on the invalid handle
	a_handle_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		handle_ctr_q != '0)
		else $error("handle counter reached zero");

	// live count bounded by the table
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= IDX_W'(SLOTS))
		else $error("live task count above table size");

	// run count saturates
	a_run_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pass_count_q <= RUN_MAX)
		else $error("pass run count above saturation");

	// a result beat only appears from the response state
	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result raised outside response state");

endmodule

`default_nettype wire

// File: dv/priority_task_table_dispatcher_tb.sv
`default_nettype none

module priority_task_table_dispatcher_tb;
	import ptd_pkg::*;

	// slowest request (dispatch over every level) plus margin
	localparam int DRAIN_CYCLES = LEVELS * (SLOTS + 1) + 4;
	// far above a run of about two thousand beats with the longest gaps and stalls
	localparam int unsigned CYCLE_LIMIT = 6_000_000;
	localparam int PHASE_ITEMS = 195;
	// request codes with no meaning to the block
	localparam int REQ_SPARE_LO = int'(REQ_QUERY) + 1;
	localparam int REQ_SPARE_HI = (1 << REQ_W) - 1;

	// shadow of the task table, kept in step with every accepted request beat
	class task_table_tracker;
		logic [HANDLE_W-1:0] handle_tab [SLOTS];
		logic [PRI_W-1:0]    prio_tab   [SLOTS];
		logic [RS_W-1:0]     state_tab  [SLOTS];
		int unsigned         capacity;
		int unsigned         live;
		logic [HANDLE_W-1:0] issue_handle;
		int unsigned         run_slot;
		bit                  run_valid;
		int unsigned         scan_lvl;
		int unsigned         scan_pos;
		int unsigned         pass_runs;
		rsp_t                replies_due [$];
		int unsigned         wraps, passes, noted, checked, errors;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				handle_tab[i] = '0;
				prio_tab[i]   = '0;
				state_tab[i]  = RS_READY;
			end
			capacity     = 32'(SLOTS_IN_USE_RST);
			live         = 0;
			issue_handle = HANDLE_W'(1);
			run_slot     = 0;
			run_valid    = 1'b0;
			scan_lvl     = LEVELS - 1;
			scan_pos     = 0;
			pass_runs    = 0;
			wraps        = 0;
			passes       = 0;
			noted        = 0;
			checked      = 0;
			errors       = 0;
		endfunction

		function void set_capacity(input logic [CFG_W-1:0] v);
			capacity = 32'(v);
		endfunction

		function int unsigned usable();
			return (capacity > SLOTS) ? SLOTS : capacity;
		endfunction

		function int unsigned find_slot(input logic [HANDLE_W-1:0] h);
			for (int i = 0; i < usable(); i++)
				if (handle_tab[i] == h)
					return i;
			return SLOTS;
		endfunction

		function rsp_t table_reply(input req_t r);
			rsp_t        a;
			int unsigned n, s, found;
			a        = '0;
			a.status = STS_WRONG;
			n        = usable();
			case (r.req_type)
			REQ_CREATE: begin
				s = SLOTS;
				if (live < n)
					for (int i = 0; i < n; i++)
						if (handle_tab[i] == '0) begin
							s = i;
							break;
						end
				if (s >= SLOTS) begin
					a.status = STS_FULL;
				end else begin
					handle_tab[s]     = issue_handle;
					prio_tab[s]       = r.task_priority;
					state_tab[s]      = RS_READY;
					a.status          = STS_OK;
					a.result_handle   = issue_handle;
					a.result_priority = r.task_priority;
					a.result_state    = RS_READY;
					issue_handle      = issue_handle + HANDLE_W'(1);
					if (issue_handle == '0) begin
						issue_handle = HANDLE_W'(1);
						wraps++;
					end
					live = (live + 1) % (1 << CFG_W);
				end
			end
			REQ_DESTROY, REQ_QUERY: begin
				if (r.task_handle == '0) begin
					a.status = STS_BAD_HANDLE;
				end else begin
					s = find_slot(r.task_handle);
					if (s >= SLOTS) begin
						a.status = STS_NOT_FOUND;
					end else if (r.req_type == REQ_QUERY) begin
						a.status          = STS_OK;
						a.result_handle   = r.task_handle;
						a.result_priority = prio_tab[s];
						a.result_state    = state_tab[s];
					end else if (state_tab[s] == RS_RUNNING) begin
						a.status = STS_WRONG;
					end else begin
						handle_tab[s] = '0;
						prio_tab[s]   = '0;
						state_tab[s]  = RS_READY;
						if (live > 0)
							live--;
						a.status = STS_OK;
					end
				end
			end
			REQ_DISPATCH: begin
				if (!run_valid) begin
					found = SLOTS;
					while (1'b1) begin
						for (int i = scan_pos; i < n; i++)
							if (handle_tab[i] != '0 && 32'(prio_tab[i]) == scan_lvl &&
								(state_tab[i] == RS_READY || state_tab[i] == RS_YIELDED)) begin
								found = i;
								break;
							end
						if (found < SLOTS || scan_lvl == 0)
							break;
						scan_lvl--;
						scan_pos = 0;
					end
					if (found < SLOTS) begin
						state_tab[found] = RS_RUNNING;
						run_slot         = found;
						run_valid        = 1'b1;
						scan_pos         = found + 1;
						if (pass_runs < 32'(RUN_MAX))
							pass_runs++;
						a.status          = STS_OK;
						a.result_handle   = handle_tab[found];
						a.result_priority = prio_tab[found];
						a.result_state    = RS_RUNNING;
					end else begin
						a.status    = STS_DONE;
						a.tasks_run = RUN_W'(pass_runs);
						passes++;
						scan_lvl  = LEVELS - 1;
						scan_pos  = 0;
						pass_runs = 0;
					end
				end
			end
			REQ_COMPLETE: begin
				if (run_valid) begin
					state_tab[run_slot] = r.outcome ? RS_TERMINATED : RS_YIELDED;
					run_valid           = 1'b0;
					a.status            = STS_OK;
					a.result_handle     = handle_tab[run_slot];
					a.result_priority   = prio_tab[run_slot];
					a.result_state      = state_tab[run_slot];
				end
			end
			default: ;
			endcase
			return a;
		endfunction

		function void note_request(input req_t r);
			replies_due.push_back(table_reply(r));
			noted++;
		endfunction

		function void check_response(input rsp_t got);
			rsp_t want;
			if (replies_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected reply: status %0d handle %0d pri %0d state %0d run %0d",
						got.status, got.result_handle, got.result_priority,
						got.result_state, got.tasks_run);
				return;
			end
			want = replies_due.pop_front();
			checked++;
			if (got.status !== want.status || got.result_handle !== want.result_handle ||
				got.result_priority !== want.result_priority ||
				got.result_state !== want.result_state || got.tasks_run !== want.tasks_run) begin
				errors++;
				if (errors <= 10)
					$display({"reply mismatch: expected status %0d handle %0d pri %0d ",
						"state %0d run %0d, got status %0d handle %0d pri %0d state %0d run %0d"},
						want.status, want.result_handle, want.result_priority,
						want.result_state, want.tasks_run, got.status, got.result_handle,
						got.result_priority, got.result_state, got.tasks_run);
			end
		endfunction

		function int unsigned pending();
			return replies_due.size();
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	req_t                in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	rsp_t                out_data;
	logic                cfg_we    = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;

	task_table_tracker   sb;
	// no gaps and no new stall bursts while set
	bit                  calm         = 1'b0;
	int unsigned         stall_left   = 0;
	int unsigned         cycle_count  = 0;
	int unsigned         cfg_writes   = 0;
	int unsigned         phase_caps [10] = '{16, 5, 0, 16, 1, 31, 9, 17, 2, 16};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	priority_task_table_dispatcher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// watchdog: a hung handshake or a lost reply ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding",
				cycle_count, sb.pending());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// reply side: check each accepted beat, then pick the stall for the next cycle
	// (mostly short bursts, now and then a long one, none started while calm)
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_response(out_data);
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(99) < 30) begin
			stall_left = ($urandom_range(9) == 0) ? $urandom_range(12, 50) : $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic req_t make_req(input logic [REQ_W-1:0] kind,
		input logic [HANDLE_W-1:0] h, input logic [PRI_W-1:0] p, input logic oc);
		req_t r;
		r.req_type      = kind;
		r.task_handle   = h;
		r.task_priority = p;
		r.outcome       = oc;
		return r;
	endfunction

	// mostly a handle that sits in the table (possibly past the usable range),
	// otherwise zero, the next one to be issued, all ones or noise
	function automatic logic [HANDLE_W-1:0] pick_handle();
		logic [HANDLE_W-1:0] held [$];
		int unsigned         roll;
		roll = $urandom_range(99);
		for (int i = 0; i < SLOTS; i++)
			if (sb.handle_tab[i] != '0)
				held.push_back(sb.handle_tab[i]);
		if (roll < 70 && held.size() > 0)
			return held[$urandom_range(held.size() - 1)];
		if (roll < 78)
			return '0;
		if (roll < 84)
			return sb.issue_handle;
		if (roll < 88)
			return '1;
		return HANDLE_W'($urandom);
	endfunction

	// follows the dispatch / complete rhythm most of the time, with the odd
	// out-of-turn request thrown in; unused fields carry noise
	function automatic req_t next_random_request();
		req_t        r;
		int unsigned roll;
		r    = make_req(REQ_QUERY, HANDLE_W'($urandom), PRI_W'($urandom), 1'($urandom));
		roll = $urandom_range(99);
		if (sb.run_valid) begin
			if (roll < 62) begin
				r.req_type = REQ_COMPLETE;
			end else if (roll < 74) begin
				r.req_type = REQ_DISPATCH;
			end else if (roll < 82) begin
				r.req_type    = REQ_DESTROY;
				r.task_handle = (roll < 78) ? sb.handle_tab[sb.run_slot] : pick_handle();
			end else if (roll < 90) begin
				r.task_handle = pick_handle();
			end else if (roll < 97) begin
				r.req_type = REQ_CREATE;
			end else begin
				r.req_type = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
			end
		end else begin
			if (roll < 25) begin
				r.req_type = REQ_CREATE;
			end else if (roll < 55) begin
				r.req_type = REQ_DISPATCH;
			end else if (roll < 70) begin
				r.req_type    = REQ_DESTROY;
				r.task_handle = pick_handle();
			end else if (roll < 88) begin
				r.task_handle = pick_handle();
			end else if (roll < 94) begin
				r.req_type = REQ_COMPLETE;
			end else begin
				r.req_type = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
			end
		end
		return r;
	endfunction

	// present one request beat and hold it until taken; valid stays high into
	// the next call when no gap follows
	task automatic send_req(input req_t r);
		int unsigned gap, roll;
		in_data  <= r;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(r);
		roll = $urandom_range(99);
		if (calm || roll < 55)
			gap = 0;
		else if (roll < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// capacity only changes with the block idle
	task automatic write_capacity(input logic [CFG_W-1:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(v);
		cfg_writes++;
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, refused requests, one task per priority level
		send_req(make_req(REQ_COMPLETE, HANDLE_W'($urandom), PRI_W'($urandom), 1'b0));
		send_req(make_req(REQ_DISPATCH, HANDLE_W'($urandom), PRI_W'($urandom), 1'b1));
		send_req(make_req(REQ_DESTROY, '0, PRI_W'($urandom), 1'($urandom)));
		send_req(make_req(REQ_QUERY, '0, PRI_W'($urandom), 1'($urandom)));
		send_req(make_req(REQ_QUERY, '1, PRI_W'($urandom), 1'($urandom)));
		send_req(make_req(REQ_CREATE, '1, 2'd3, 1'b1));
		send_req(make_req(REQ_CREATE, '0, 2'd0, 1'b0));
		send_req(make_req(REQ_CREATE, HANDLE_W'($urandom), 2'd2, 1'b0));
		send_req(make_req(REQ_CREATE, HANDLE_W'($urandom), 2'd1, 1'b1));
		send_req(make_req(REQ_QUERY, 16'd1, PRI_W'($urandom), 1'($urandom)));
		// a full pass: highest level first, both outcomes
		send_req(make_req(REQ_DISPATCH, HANDLE_W'($urandom), PRI_W'($urandom), 1'b0));
		// dispatch and destroy while a task is running are both refused
		send_req(make_req(REQ_DISPATCH, HANDLE_W'($urandom), PRI_W'($urandom), 1'b1));
		send_req(make_req(REQ_DESTROY, 16'd1, PRI_W'($urandom), 1'($urandom)));
		send_req(make_req(REQ_COMPLETE, HANDLE_W'($urandom), PRI_W'($urandom), 1'b0));
		send_req(make_req(REQ_DISPATCH, HANDLE_W'($urandom), PRI_W'($urandom), 1'b0));
		send_req(make_req(REQ_COMPLETE, HANDLE_W'($urandom), PRI_W'($urandom), 1'b1));
		send_req(make_req(REQ_DISPATCH, HANDLE_W'($urandom), PRI_W'($urandom), 1'b1));
		send_req(make_req(REQ_COMPLETE, HANDLE_W'($urandom), PRI_W'($urandom), 1'b0));
		send_req(make_req(REQ_DISPATCH, HANDLE_W'($urandom), PRI_W'($urandom), 1'b0));
		send_req(make_req(REQ_COMPLETE, HANDLE_W'($urandom), PRI_W'($urandom), 1'b1));
		// pass end with its run count
		send_req(make_req(REQ_DISPATCH, HANDLE_W'($urandom), PRI_W'($urandom), 1'b0));
		for (int k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++)
			send_req(make_req(REQ_W'(k), HANDLE_W'($urandom), PRI_W'($urandom),
				1'($urandom)));
		send_req(make_req(REQ_DESTROY, 16'd2, PRI_W'($urandom), 1'($urandom)));
		send_req(make_req(REQ_DESTROY, 16'd2, PRI_W'($urandom), 1'($urandom)));
		send_req(make_req(REQ_QUERY, 16'd3, PRI_W'($urandom), 1'($urandom)));

		// four usable slots: fill them, one create too many, then read slot 0 back
		write_capacity(CFG_W'(4));
		calm = 1'b1;
		while (sb.live < sb.usable())
			send_req(make_req(REQ_CREATE, HANDLE_W'($urandom), PRI_W'($urandom), 1'b0));
		send_req(make_req(REQ_CREATE, HANDLE_W'($urandom), PRI_W'($urandom), 1'b1));
		send_req(make_req(REQ_QUERY, sb.handle_tab[0], PRI_W'($urandom), 1'($urandom)));

		// random phases over a spread of capacities, zero and out of range too
		foreach (phase_caps[p]) begin
			write_capacity(CFG_W'(phase_caps[p]));
			calm = (p == 3);
			repeat (PHASE_ITEMS)
				send_req(next_random_request());
			// leave nothing running across a capacity change
			if (sb.run_valid)
				send_req(make_req(REQ_COMPLETE, HANDLE_W'($urandom), PRI_W'($urandom),
					1'($urandom)));
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d requests with %0d replies checked over %0d capacity writes",
			sb.noted, sb.checked, cfg_writes);
		$display("handle counter wrapped %0d time(s), %0d scheduling passes ended",
			sb.wraps, sb.passes);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
